>>> rtl/eds_pkg.sv
// Shared types, constants and width helpers for the edge dislocation stress block.
`timescale 1ns / 1ps

package eds_pkg;

  localparam int COORD_W         = 32;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_MUL_DIGIT   = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int MUL_LANES       = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_CORE_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORE_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CORE_WSQ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFACTOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEG_SIGN   = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } eds_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] stress_xx;
    logic signed [COORD_W-1:0] stress_yy;
    logic signed [COORD_W-1:0] stress_xy;
  } eds_out_t;

  // Result signs of the three stress components.
  typedef struct packed {
    logic neg_xx;
    logic neg_yy;
    logic neg_xy;
  } eds_sgn_t;

  function automatic int eds_max(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Magnitude of a coordinate difference.
  function automatic int eds_mag_w(input int cw);
    return cw + 1;
  endfunction

  // Width of R = dx^2 + dy^2 + a2.
  function automatic int eds_r_w(input int cw, input int fb);
    return eds_max(2 * (cw + 1), cw + fb) + 2;
  endfunction

  // Width of the polynomial factors (up to three times R).
  function automatic int eds_f_w(input int cw, input int fb);
    return eds_r_w(cw, fb) + 2;
  endfunction

  // Width of prefactor times coordinate magnitude.
  function automatic int eds_dc_w(input int cw);
    return 2 * cw + 1;
  endfunction

  // Width of the scaled dividend.
  function automatic int eds_num_w(input int cw, input int fb);
    return eds_dc_w(cw) + eds_f_w(cw, fb) + fb + 1;
  endfunction

  function automatic int eds_den_w(input int cw, input int fb);
    return 2 * eds_r_w(cw, fb);
  endfunction

endpackage

>>> rtl/edge_dislocation_stress.sv
// Top level of the regularized edge dislocation stress pipeline.
`timescale 1ns / 1ps
// Path from request to strobe: offsets, first multiplier bank, terms, second multiplier bank,
//   divider entry, quotient stages and rounding; default widths are 32-bit Q16.16, digit 16.
// Throughput: one request per cycle; busy is always low and the result strobe cannot stall.
// Latency is dominated by the 33-stage quotient pipeline, which retires one quotient bit per stage.
// Reset (synchronous, rst_n low) clears all valid bits and loads the register defaults:
//   core at the origin, core width squared 1.0, prefactor 1.0, positive dislocation.

module edge_dislocation_stress #(
  parameter int FRAC_BITS = eds_pkg::DEF_FRAC_BITS,
  parameter int MUL_DIGIT = eds_pkg::DEF_MUL_DIGIT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  eds_pkg::eds_in_t                  in_point,
  output logic                              out_valid,
  output eds_pkg::eds_out_t                 out_result,
  input  logic                              cfg_we,
  input  logic [eds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [eds_pkg::COORD_W-1:0]       cfg_data
);
  import eds_pkg::*;

  localparam int CW   = COORD_W;
  localparam int MW   = eds_mag_w(CW);
  localparam int RW   = eds_r_w(CW, FRAC_BITS);
  localparam int FW   = eds_f_w(CW, FRAC_BITS);
  localparam int DCW  = eds_dc_w(CW);
  localparam int NPW  = DCW + FW;
  localparam int NW   = eds_num_w(CW, FRAC_BITS);
  localparam int DENW = eds_den_w(CW, FRAC_BITS);
  localparam int WA2  = eds_max(RW, DCW);

  // Configuration registers. The user must change them only while the pipeline is empty; the block
  // itself does not enforce this. The stages that use them read them directly.
  logic [CW-1:0] core_x_r, core_y_r, core_wsq_r, pref_r;
  logic          neg_sign_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_x_r   <= '0;
      core_y_r   <= '0;
      core_wsq_r <= CW'(1) << FRAC_BITS;
      pref_r     <= CW'(1) << FRAC_BITS;
      neg_sign_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CORE_X:    core_x_r   <= cfg_data;
        CFG_CORE_Y:    core_y_r   <= cfg_data;
        CFG_CORE_WSQ:  core_wsq_r <= cfg_data;
        CFG_PREFACTOR: pref_r     <= cfg_data;
        CFG_NEG_SIGN:  neg_sign_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Every cycle can take a new request; nothing upstream ever waits.
  assign busy = 1'b0;

  // Stage 1: offsets from the dislocation line, split into sign and magnitude.
  logic [MW-1:0] dx, dy, mx_nxt, my_nxt;
  logic          s1_vld_r, s1_sx_r, s1_sy_r;
  logic [MW-1:0] s1_mx_r, s1_my_r;

  assign dx     = {in_point.point_x[CW-1], in_point.point_x} - {core_x_r[CW-1], core_x_r};
  assign dy     = {in_point.point_y[CW-1], in_point.point_y} - {core_y_r[CW-1], core_y_r};
  assign mx_nxt = dx[MW-1] ? (~dx + MW'(1)) : dx;
  assign my_nxt = dy[MW-1] ? (~dy + MW'(1)) : dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_mx_r <= mx_nxt;
    s1_my_r <= my_nxt;
    s1_sx_r <= dx[MW-1];
    s1_sy_r <= dy[MW-1];
  end

  // First multiplier bank: dx^2, dy^2 and the prefactor times each magnitude.
  logic [MW-1:0]   m1_a [MUL_LANES];
  logic [MW-1:0]   m1_b [MUL_LANES];
  logic [2*MW-1:0] m1_p [MUL_LANES];
  logic [1:0]      m1_side;
  logic            m1_vld;

  assign m1_a[0] = s1_mx_r;
  assign m1_b[0] = s1_mx_r;
  assign m1_a[1] = s1_my_r;
  assign m1_b[1] = s1_my_r;
  assign m1_a[2] = MW'(pref_r);
  assign m1_b[2] = s1_my_r;
  assign m1_a[3] = MW'(pref_r);
  assign m1_b[3] = s1_mx_r;

  eds_mul #(
    .WA    (MW),
    .WB    (MW),
    .LANES (MUL_LANES),
    .SW    (2),
    .DIG   (MUL_DIGIT)
  ) u_mul_sq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s1_vld_r),
    .a       (m1_a),
    .b       (m1_b),
    .side    ({s1_sx_r, s1_sy_r}),
    .out_vld (m1_vld),
    .p       (m1_p),
    .side_o  (m1_side)
  );

  // R and the three numerator polynomials as magnitudes, with the signs of the three results.
  logic            t_vld;
  logic [RW-1:0]   t_r;
  logic [FW-1:0]   t_n, t_mf, t_kf;
  logic [DCW-1:0]  t_dcy, t_dcx;
  eds_sgn_t        t_sgn;

  eds_terms #(
    .CW        (CW),
    .FRAC_BITS (FRAC_BITS)
  ) u_terms (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (m1_vld),
    .x2      (m1_p[0]),
    .y2      (m1_p[1]),
    .a2      (core_wsq_r),
    .s       (neg_sign_r),
    .sx      (m1_side[1]),
    .sy      (m1_side[0]),
    .dcy     (DCW'(m1_p[2])),
    .dcx     (DCW'(m1_p[3])),
    .out_vld (t_vld),
    .r       (t_r),
    .n       (t_n),
    .mf      (t_mf),
    .kf      (t_kf),
    .dcy_o   (t_dcy),
    .dcx_o   (t_dcx),
    .sgn     (t_sgn)
  );

  // Second multiplier bank: the denominator R^2 and the three dividends.
  logic [WA2-1:0]    m2_a [MUL_LANES];
  logic [FW-1:0]     m2_b [MUL_LANES];
  logic [WA2+FW-1:0] m2_p [MUL_LANES];
  logic [2:0]        m2_side;
  logic              m2_vld;
  eds_sgn_t          m2_sgn;

  assign m2_a[0] = WA2'(t_r);
  assign m2_b[0] = FW'(t_r);
  assign m2_a[1] = WA2'(t_dcy);
  assign m2_b[1] = t_n;
  assign m2_a[2] = WA2'(t_dcy);
  assign m2_b[2] = t_mf;
  assign m2_a[3] = WA2'(t_dcx);
  assign m2_b[3] = t_kf;

  eds_mul #(
    .WA    (WA2),
    .WB    (FW),
    .LANES (MUL_LANES),
    .SW    (3),
    .DIG   (MUL_DIGIT)
  ) u_mul_num (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (t_vld),
    .a       (m2_a),
    .b       (m2_b),
    .side    (t_sgn),
    .out_vld (m2_vld),
    .p       (m2_p),
    .side_o  (m2_side)
  );

  assign m2_sgn = m2_side;

  // The quotient carries FRAC_BITS fraction bits plus one rounding bit.
  logic [DENW-1:0] den;
  logic [NW-1:0]   num_xx, num_yy, num_xy;

  assign den    = DENW'(m2_p[0]);
  assign num_xx = {NPW'(m2_p[1]), {(FRAC_BITS + 1){1'b0}}};
  assign num_yy = {NPW'(m2_p[2]), {(FRAC_BITS + 1){1'b0}}};
  assign num_xy = {NPW'(m2_p[3]), {(FRAC_BITS + 1){1'b0}}};

  logic                 d_vld_xx, d_vld_yy, d_vld_xy;
  logic signed [CW-1:0] res_xx, res_yy, res_xy;

  eds_div #(.CW(CW), .NW(NW), .DENW(DENW)) u_div_xx (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (m2_vld),
    .num     (num_xx),
    .den     (den),
    .neg     (m2_sgn.neg_xx),
    .out_vld (d_vld_xx),
    .res     (res_xx)
  );

  eds_div #(.CW(CW), .NW(NW), .DENW(DENW)) u_div_yy (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (m2_vld),
    .num     (num_yy),
    .den     (den),
    .neg     (m2_sgn.neg_yy),
    .out_vld (d_vld_yy),
    .res     (res_yy)
  );

  eds_div #(.CW(CW), .NW(NW), .DENW(DENW)) u_div_xy (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (m2_vld),
    .num     (num_xy),
    .den     (den),
    .neg     (m2_sgn.neg_xy),
    .out_vld (d_vld_xy),
    .res     (res_xy)
  );

  // The three dividers run in lockstep, so their strobes always agree.
  assign out_valid            = d_vld_xx && d_vld_yy && d_vld_xy;
  assign out_result.stress_xx = res_xx;
  assign out_result.stress_yy = res_yy;
  assign out_result.stress_xy = res_xy;

endmodule

>>> rtl/eds_mul.sv
// Multi-lane pipelined multiplier that consumes one digit of the multiplier per stage.
`timescale 1ns / 1ps

module eds_mul #(
  parameter int WA    = 33,
  parameter int WB    = 33,
  parameter int LANES = 4,
  parameter int SW    = 2,
  parameter int DIG   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [WA-1:0]       a [LANES],
  input  logic [WB-1:0]       b [LANES],
  input  logic [SW-1:0]       side,
  output logic                out_vld,
  output logic [WA+WB-1:0]    p [LANES],
  output logic [SW-1:0]       side_o
);

  localparam int NS = (WB + DIG - 1) / DIG;
  localparam int BW = NS * DIG;
  localparam int PW = WA + WB;

  logic            vld_r  [NS];
  logic [SW-1:0]   side_r [NS];
  logic [WA-1:0]   a_r    [NS][LANES];
  logic [WB-1:0]   b_r    [NS][LANES];
  logic [PW-1:0]   acc_r  [NS][LANES];

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic          vld_s;
    logic [SW-1:0] side_s;

    if (k == 0) begin : g_first
      assign vld_s  = in_vld;
      assign side_s = side;
    end else begin : g_next
      assign vld_s  = vld_r[k-1];
      assign side_s = side_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= side_s;
    end

    for (genvar l = 0; l < LANES; l++) begin : g_ln
      logic [WA-1:0]     a_s;
      logic [WB-1:0]     b_s;
      logic [PW-1:0]     acc_s;
      logic [BW-1:0]     bz;
      logic [WA+DIG-1:0] pp;

      if (k == 0) begin : g_first
        assign a_s   = a[l];
        assign b_s   = b[l];
        assign acc_s = '0;
      end else begin : g_next
        assign a_s   = a_r[k-1][l];
        assign b_s   = b_r[k-1][l];
        assign acc_s = acc_r[k-1][l];
      end

      assign bz = BW'(b_s);
      assign pp = a_s * bz[k*DIG +: DIG];

      always_ff @(posedge clk) begin
        a_r[k][l]   <= a_s;
        b_r[k][l]   <= b_s;
        acc_r[k][l] <= acc_s + (PW'(pp) << (k * DIG));
      end

      if (k == NS - 1) begin : g_out
        assign p[l] = acc_r[k][l];
      end
    end
  end

  assign out_vld = vld_r[NS-1];
  assign side_o  = side_r[NS-1];

endmodule

>>> rtl/eds_terms.sv
// Register stage that forms R and the three polynomial factors with their signs.
`timescale 1ns / 1ps

module eds_terms #(
  parameter int CW        = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_vld,
  input  logic [2*eds_pkg::eds_mag_w(CW)-1:0]        x2,
  input  logic [2*eds_pkg::eds_mag_w(CW)-1:0]        y2,
  input  logic [CW-1:0]                              a2,
  input  logic                                       s,
  input  logic                                       sx,
  input  logic                                       sy,
  input  logic [eds_pkg::eds_dc_w(CW)-1:0]           dcy,
  input  logic [eds_pkg::eds_dc_w(CW)-1:0]           dcx,
  output logic                                       out_vld,
  output logic [eds_pkg::eds_r_w(CW, FRAC_BITS)-1:0] r,
  output logic [eds_pkg::eds_f_w(CW, FRAC_BITS)-1:0] n,
  output logic [eds_pkg::eds_f_w(CW, FRAC_BITS)-1:0] mf,
  output logic [eds_pkg::eds_f_w(CW, FRAC_BITS)-1:0] kf,
  output logic [eds_pkg::eds_dc_w(CW)-1:0]           dcy_o,
  output logic [eds_pkg::eds_dc_w(CW)-1:0]           dcx_o,
  output eds_pkg::eds_sgn_t                          sgn
);
  import eds_pkg::*;

  localparam int FW = eds_f_w(CW, FRAC_BITS);

  logic [FW-1:0] x2e, y2e, ae, t1, ty, n_nxt, mf_nxt, kf_nxt, r_nxt;
  logic          mneg, kneg;
  eds_sgn_t      sgn_nxt;

  logic                    vld_r;
  logic [FW-1:0]           r_r, n_r, mf_r, kf_r;
  logic [eds_dc_w(CW)-1:0] dcy_r, dcx_r;
  eds_sgn_t                sgn_r;

  always_comb begin
    x2e    = FW'(x2);
    y2e    = FW'(y2);
    ae     = FW'(a2) << FRAC_BITS;
    r_nxt  = x2e + y2e + ae;
    t1     = x2e + ae;
    ty     = y2e + ae;
    n_nxt  = (t1 << 1) + t1 + y2e;
    mneg   = x2e < ty;
    mf_nxt = mneg ? (ty - x2e) : (x2e - ty);
    kneg   = t1 < y2e;
    kf_nxt = kneg ? (y2e - t1) : (t1 - y2e);
    sgn_nxt.neg_xx = !(s ^ sy);
    sgn_nxt.neg_yy = s ^ sy ^ mneg;
    sgn_nxt.neg_xy = s ^ sx ^ kneg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    n_r   <= n_nxt;
    mf_r  <= mf_nxt;
    kf_r  <= kf_nxt;
    dcy_r <= dcy;
    dcx_r <= dcx;
    sgn_r <= sgn_nxt;
  end

  assign out_vld = vld_r;
  assign r       = r_r[eds_r_w(CW, FRAC_BITS)-1:0];
  assign n       = n_r;
  assign mf      = mf_r;
  assign kf      = kf_r;
  assign dcy_o   = dcy_r;
  assign dcx_o   = dcx_r;
  assign sgn     = sgn_r;

endmodule

>>> rtl/eds_div.sv
// Pipelined restoring divider, one quotient bit per stage, with rounding and saturation.
`timescale 1ns / 1ps

module eds_div #(
  parameter int CW   = 32,
  parameter int NW   = 160,
  parameter int DENW = 136
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [NW-1:0]        num,
  input  logic [DENW-1:0]      den,
  input  logic                 neg,
  output logic                 out_vld,
  output logic signed [CW-1:0] res
);
  import eds_pkg::*;

  localparam int VW = eds_max(NW, DENW + CW + 1);
  localparam logic [CW:0] HALF = (CW+1)'(1) << (CW - 1);
  localparam logic [CW:0] FULL = (CW+1)'(1) << CW;

  // Entry stage: overflow and zero-divisor checks.
  logic              pv_r, pneg_r, psat_r, pzero_r;
  logic [VW-1:0]     prem_r;
  logic [DENW-1:0]   pden_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    prem_r  <= VW'(num);
    pden_r  <= den;
    pneg_r  <= neg;
    psat_r  <= VW'(num) >= (VW'(den) << (CW + 1));
    pzero_r <= den == '0;
  end

  logic            vld_r  [CW+1];
  logic [VW-1:0]   rem_r  [CW+1];
  logic [DENW-1:0] den_r  [CW+1];
  logic [CW:0]     q_r    [CW+1];
  logic            neg_r  [CW+1];
  logic            sat_r  [CW+1];
  logic            zero_r [CW+1];

  for (genvar j = 0; j <= CW; j++) begin : g_bit
    localparam int BI = CW - j;
    logic            vld_s, neg_s, sat_s, zero_s, ge;
    logic [VW-1:0]   rem_s, dsh;
    logic [DENW-1:0] den_s;
    logic [CW:0]     q_s;

    if (j == 0) begin : g_first
      assign vld_s  = pv_r;
      assign rem_s  = prem_r;
      assign den_s  = pden_r;
      assign q_s    = '0;
      assign neg_s  = pneg_r;
      assign sat_s  = psat_r;
      assign zero_s = pzero_r;
    end else begin : g_next
      assign vld_s  = vld_r[j-1];
      assign rem_s  = rem_r[j-1];
      assign den_s  = den_r[j-1];
      assign q_s    = q_r[j-1];
      assign neg_s  = neg_r[j-1];
      assign sat_s  = sat_r[j-1];
      assign zero_s = zero_r[j-1];
    end

    assign dsh = VW'(den_s) << BI;
    assign ge  = rem_s >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j]  <= ge ? (rem_s - dsh) : rem_s;
      q_r[j]    <= q_s | ((CW+1)'(ge) << BI);
      den_r[j]  <= den_s;
      neg_r[j]  <= neg_s;
      sat_r[j]  <= sat_s;
      zero_r[j] <= zero_s;
    end
  end

  // Round half away from zero on the magnitude, then clamp to the signed range.
  logic [CW+1:0] mr;
  logic [CW:0]   m, mc;
  logic [CW-1:0] res_nxt;
  logic          ovld_r;
  logic [CW-1:0] res_r;

  always_comb begin
    mr = (CW+2)'(q_r[CW]) + (CW+2)'(1);
    m  = sat_r[CW] ? FULL : mr[CW+1:1];
    if (zero_r[CW]) begin
      mc      = '0;
      res_nxt = '0;
    end else if (neg_r[CW]) begin
      mc      = (m > HALF) ? HALF : m;
      res_nxt = CW'((~mc) + (CW+1)'(1));
    end else begin
      mc      = (m > HALF - 1'b1) ? (HALF - 1'b1) : m;
      res_nxt = CW'(mc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= vld_r[CW];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_vld = ovld_r;
  assign res     = res_r;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the regularized edge dislocation stress block.
`timescale 1ns / 1ps

module tb_top;
  import eds_pkg::*;

  typedef logic [255:0] wide_t;

  // The scoreboard holds its own copy of the dislocation registers and a
  // queue of predicted stress triples, oldest first.
  class stress_scoreboard;
    logic [COORD_W-1:0] core_x, core_y, core_wsq, prefactor;
    logic               neg_sign;
    eds_out_t           pending[$];
    int                 errors;
    int                 checked;

    function new();
      core_x    = '0;
      core_y    = '0;
      core_wsq  = 32'h0001_0000;
      prefactor = 32'h0001_0000;
      neg_sign  = 1'b0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
      case (idx)
        CFG_CORE_X:    core_x = data;
        CFG_CORE_Y:    core_y = data;
        CFG_CORE_WSQ:  core_wsq = data;
        CFG_PREFACTOR: prefactor = data;
        CFG_NEG_SIGN:  neg_sign = data[0];
        default: ;
      endcase
    endfunction

    // Rounded, saturated value of prefactor * mag * factor / den in Q16.16.
    function logic [COORD_W-1:0] scaled_quotient(logic [32:0] mag, wide_t factor, bit neg,
                                                 wide_t den);
      wide_t       num, q;
      logic [63:0] m;
      if (den == 0) return '0;
      num = (wide_t'(prefactor) * wide_t'(mag) * factor) << (DEF_FRAC_BITS + 1);
      if (num == 0) return '0;
      if (num >= (den << (COORD_W + 1))) begin
        m = 64'h1_0000_0000;
      end else begin
        q = num / den;
        m = 64'((q + 1) >> 1);
      end
      if (neg) begin
        if (m > 64'h8000_0000) m = 64'h8000_0000;
        return 32'(-m);
      end
      if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
      return m[31:0];
    endfunction

    function eds_out_t predict_stress(eds_in_t p);
      logic signed [33:0] dx, dy;
      logic [32:0]        mx, my;
      bit                 sx, sy, mneg, kneg;
      wide_t              x2, y2, a2, r, den, n, t, mf, kf;
      eds_out_t           res;
      dx = {{2{p.point_x[31]}}, p.point_x} - {{2{core_x[31]}}, core_x};
      dy = {{2{p.point_y[31]}}, p.point_y} - {{2{core_y[31]}}, core_y};
      sx = dx[33];
      sy = dy[33];
      mx = sx ? 33'(-dx) : 33'(dx);
      my = sy ? 33'(-dy) : 33'(dy);
      x2 = wide_t'(mx) * wide_t'(mx);
      y2 = wide_t'(my) * wide_t'(my);
      a2 = wide_t'(core_wsq) << DEF_FRAC_BITS;
      r = x2 + y2 + a2;
      den = r * r;
      n = 3 * (x2 + a2) + y2;
      t = y2 + a2;
      mneg = x2 < t;
      mf = mneg ? t - x2 : x2 - t;
      t = x2 + a2;
      kneg = t < y2;
      kf = kneg ? y2 - t : t - y2;
      res.stress_xx = scaled_quotient(my, n, !(neg_sign ^ sy), den);
      res.stress_yy = scaled_quotient(my, mf, neg_sign ^ sy ^ mneg, den);
      res.stress_xy = scaled_quotient(mx, kf, neg_sign ^ sx ^ kneg, den);
      return res;
    endfunction

    function void note_request(eds_in_t p);
      pending.push_back(predict_stress(p));
    endfunction

    function void check_result(eds_out_t got);
      eds_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.stress_xx !== want.stress_xx) begin
        $display("%0t: stress_xx expected %h actual %h", $time, want.stress_xx, got.stress_xx);
        errors++;
      end
      if (got.stress_yy !== want.stress_yy) begin
        $display("%0t: stress_yy expected %h actual %h", $time, want.stress_yy, got.stress_yy);
        errors++;
      end
      if (got.stress_xy !== want.stress_xy) begin
        $display("%0t: stress_xy expected %h actual %h", $time, want.stress_xy, got.stress_xy);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY     = 45;
  localparam int CYCLE_LIMIT = 200000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  eds_in_t               in_point = '0;
  logic                  out_valid;
  eds_out_t              out_result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [COORD_W-1:0]    cfg_data = '0;

  stress_scoreboard sb = new();
  int  cycle_count = 0;
  int  requests_sent = 0;
  bit  gaps_on = 1'b1;

  always #5 clk = ~clk;

  edge_dislocation_stress uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_point(in_point),
    .out_valid(out_valid), .out_result(out_result), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Results cannot be held off, so every strobe is checked at the edge ending it.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_result);
  end

  // Watchdog against a hung pipeline.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Register writes are only issued with the pipeline drained.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_dislocation(logic [31:0] cx, logic [31:0] cy, logic [31:0] wsq,
                                 logic [31:0] pref, logic neg);
    write_reg(CFG_CORE_X, cx);
    write_reg(CFG_CORE_Y, cy);
    write_reg(CFG_CORE_WSQ, wsq);
    write_reg(CFG_PREFACTOR, pref);
    write_reg(CFG_NEG_SIGN, {31'($urandom), neg});
  endtask

  // Presents one request; start stays high until the edge that accepts it.
  // A random gap ahead of it may lower start first.
  task automatic send_point(logic [31:0] px, logic [31:0] py);
    int gap;
    gap = (gaps_on && $urandom_range(99) < 21) ? $urandom_range(1, 2) : 0;
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    in_point.point_x = px;
    in_point.point_y = py;
    do @(posedge clk); while (busy);
    sb.note_request(in_point);
    requests_sent++;
  endtask

  // Lowers start and lets every predicted result come back, plus some margin.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Points near the core give unsaturated stress; far points exercise the clamp.
  task automatic random_points(int count);
    logic [31:0] px, py;
    for (int i = 0; i < count; i++) begin
      gaps_on = !(i >= count / 3 && i < count / 3 + 80);
      case ($urandom_range(3))
        0: begin
          px = $urandom;
          py = $urandom;
        end
        1: begin
          px = sb.core_x + 32'($signed(20'($urandom)));
          py = sb.core_y + 32'($signed(20'($urandom)));
        end
        default: begin
          px = sb.core_x + 32'($signed(24'($urandom)));
          py = sb.core_y + 32'($signed(24'($urandom)));
        end
      endcase
      send_point(px, py);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests under the reset defaults: the core itself, axis points,
    // the coordinate extremes and a unit diagonal.
    send_point(32'h0, 32'h0);
    send_point(32'h0001_0000, 32'h0);
    send_point(32'h0, 32'h0001_0000);
    send_point(32'hFFFF_0000, 32'hFFFF_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h0000_0001, 32'hFFFF_FFFF);
    drain();

    // Zero core width exactly on the dislocation line gives all zeros; next to it
    // the field is huge and saturates.
    set_dislocation(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0001, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFE);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0001, 32'h7FFF_FFFE);
    drain();

    // Zero prefactor silences the field; widest core width; unknown indices
    // must leave the registers alone.
    set_dislocation(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0);
    for (int i = 5; i < 8; i++) write_reg(CFG_IDX_W'(i), $urandom);
    send_point(32'h0003_0000, 32'hFFFE_0000);
    send_point(32'h1234_5678, 32'h8765_4321);
    drain();
    write_reg(CFG_PREFACTOR, 32'h0002_8000);
    send_point(32'h0003_0000, 32'hFFFE_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h0, 32'h0);
    drain();

    // Random phases, each with its own dislocation setup.
    set_dislocation(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 1'b0);
    random_points(250);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      set_dislocation($urandom, $urandom,
                      (ph == 1) ? 32'h0 :
                        ($urandom_range(1) ? $urandom : 32'($urandom_range(0, 32'h4_0000))),
                      (ph == 2) ? 32'hFFFF_FFFF : $urandom, ph[0]);
      random_points(210);
      drain();
    end

    $display("Sent %0d points over several core positions, widths, prefactors and signs;",
             requests_sent);
    $display("compared %0d stress triples, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
